### rtl/bsd_pkg.sv
// Shared types, sizes and constants for the binary square dilation block.
// No dependencies; every other file of the block but bsd_ram imports this package.
`default_nettype none

package bsd_pkg;

  // Frame and window limits
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MAX_RANGE  = 7;

  // Derived widths
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int OROW_W     = $clog2(MAX_HEIGHT);
  localparam int ROW_W      = OROW_W + 1;
  localparam int EXT_W      = COL_W + 1;
  localparam int RANGE_W    = $clog2(MAX_RANGE + 1);
  localparam int WIN_CELLS  = 2 * MAX_RANGE + 1;
  localparam int SLOT_W     = $clog2(WIN_CELLS);
  localparam int CNT_W      = 4;
  localparam int DLY_W      = 13;
  localparam int PIX_W      = 8;

  localparam logic [CNT_W-1:0] CNT_SAT = {CNT_W{1'b1}};
  localparam logic [PIX_W-1:0] MASK_ON = 8'd255;

  // Beat kinds
  localparam logic KIND_PIXEL = 1'b0;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

  // Reset values, sizes held as size minus one
  localparam logic [RANGE_W-1:0] RST_RANGE     = 3'd1;
  localparam logic [COL_W-1:0]   RST_WIDTH_M1  = 10'd639;
  localparam logic [OROW_W-1:0]  RST_HEIGHT_M1 = 10'd479;

  // Output queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

  typedef struct packed {
    logic [PIX_W-1:0] mask_value;
    logic             frame_last;
  } out_beat_t;

  // Window controls handed to the cell row
  typedef struct packed {
    logic [RANGE_W-1:0] half;
    logic [COL_W-1:0]   col_p;
    logic [COL_W-1:0]   rem;
  } win_ctrl_t;

  // Clamp a written size to 1..lim and return it minus one
  function automatic logic [COL_W-1:0] clamp_size_m1(input logic [CFG_DATA_W-1:0] v,
                                                     input logic [CFG_DATA_W-1:0] lim);
    logic [CFG_DATA_W-1:0] m1;
    if (v == '0) begin
      m1 = '0;
    end else if (v > lim) begin
      m1 = lim - CFG_DATA_W'(1);
    end else begin
      m1 = v - CFG_DATA_W'(1);
    end
    return m1[COL_W-1:0];
  endfunction

endpackage

`default_nettype wire

### rtl/bsd_if.sv
// Stream interfaces for pixel input and mask output beats.
// Depends on bsd_pkg for payload widths.
`default_nettype none

interface bsd_in_if;
  import bsd_pkg::*;
  logic             valid;
  logic             ready;
  logic             kind;
  logic [PIX_W-1:0] pixel_value;

  modport source (output valid, kind, pixel_value, input ready);
  modport sink   (input valid, kind, pixel_value, output ready);
endinterface

interface bsd_out_if;
  import bsd_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] mask_value;
  logic             frame_last;

  modport source (output valid, mask_value, frame_last, input ready);
  modport sink   (input valid, mask_value, frame_last, output ready);
endinterface

`default_nettype wire

### rtl/bsd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No package dependency.
`default_nettype none

module bsd_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port, old data on a same-address write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### rtl/bsd_cell.sv
// One cell of the horizontal window row: holds one column-hit bit.
// Depends on bsd_pkg for widths and the window control struct.
`default_nettype none

module bsd_cell (
  input  wire logic                      clk,
  input  wire logic                      advance,
  input  wire logic [bsd_pkg::SLOT_W-1:0] slot,
  input  wire bsd_pkg::win_ctrl_t        ctrl,
  input  wire logic                      bit_in,
  output logic                           bit_out,
  output logic                           hit
);
  import bsd_pkg::*;

  logic stored;
  logic in_span;
  logic fwd_ok;
  logic back_ok;

  // Shift the neighbour's bit in on every stream beat
  always_ff @(posedge clk) begin
    if (advance) begin
      stored <= bit_in;
    end
  end

  // Keep the bit only if it sits in the window and on the same row as the centre
  always_comb begin
    in_span = slot <= {ctrl.half, 1'b0};
    fwd_ok  = EXT_W'(slot) <= (EXT_W'(ctrl.col_p) + EXT_W'(ctrl.half));
    back_ok = (EXT_W'(ctrl.rem) + EXT_W'(slot)) >= EXT_W'(ctrl.half);
  end

  assign bit_out = stored;
  assign hit     = stored & in_span & fwd_ok & back_ok;

endmodule

`default_nettype wire

### rtl/bsd_chain.sv
// Row of window cells forming the horizontal half of the dilation.
// Depends on bsd_pkg and bsd_cell.
`default_nettype none

module bsd_chain (
  input  wire logic               clk,
  input  wire logic               advance,
  input  wire logic               bit_in,
  input  wire bsd_pkg::win_ctrl_t ctrl,
  output logic                    hit
);
  import bsd_pkg::*;

  logic [WIN_CELLS:0]   link;
  logic [WIN_CELLS-1:0] hits;

  assign link[0] = bit_in;

  // Cell k holds the column-hit bit of the beat k steps back
  for (genvar k = 0; k < WIN_CELLS; k++) begin : g_cell
    bsd_cell u_cell (
      .clk     (clk),
      .advance (advance),
      .slot    (SLOT_W'(k)),
      .ctrl    (ctrl),
      .bit_in  (link[k]),
      .bit_out (link[k+1]),
      .hit     (hits[k])
    );
  end

  assign hit = |hits;

endmodule

`default_nettype wire

### rtl/bsd_fifo.sv
// Small output queue that parts the mask stream from the pipeline.
// Depends on bsd_pkg for the beat type and depth.
`default_nettype none

module bsd_fifo (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  input  wire bsd_pkg::out_beat_t            push_data,
  input  wire logic                          take,
  output logic                               valid,
  output bsd_pkg::out_beat_t                 data,
  output logic [bsd_pkg::FIFO_CNT_W-1:0]     count
);
  import bsd_pkg::*;

  out_beat_t             entries [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic                  pop;

  assign valid = count != '0;
  assign pop   = valid && take;
  assign data  = entries[rd_ptr];

  // Store pushed beats
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      end
      count <= count + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
    end
  end

endmodule

`default_nettype wire

### rtl/binary_square_dilation_unit.sv
// Streaming binary dilation, square window: one beat per cycle while ready is high, pixels and
// flush ticks. A beat that releases a mask pixel passes the stage 1 and stage 2 registers and
// the output queue before it shows on the output. Throughput is one beat per clock, set by the
// read-modify-write of the per-column hit-age memory; ready is low while the queue could
// overflow and, when the raster delay exceeds the frame size, while the block pads after the last pixel.
// Reset: synchronous, restores register defaults and an empty frame; no memory clearing.
`default_nettype none

module binary_square_dilation_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_wr_en,
  input  wire logic [bsd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bsd_pkg::CFG_DATA_W-1:0] cfg_data,
  bsd_in_if.sink                             pix,
  bsd_out_if.source                          mask
);
  import bsd_pkg::*;

  // Configuration
  logic [RANGE_W-1:0] half;
  logic [COL_W-1:0]   wm1;
  logic [OROW_W-1:0]  hm1;
  logic [DLY_W-1:0]   dly;

  // Frame tracking
  logic [COL_W-1:0]  s_col, s_col_next;
  logic [ROW_W-1:0]  s_row, s_row_next;
  logic [DLY_W-1:0]  lead, lead_next;
  logic              complete, complete_next;
  logic [COL_W-1:0]  out_col, out_col_next;
  logic [OROW_W-1:0] out_row, out_row_next;

  // Beat decode
  logic              acc, is_pixel, restart_px, pad, take, beat, emit, last_p, set_px;
  logic [COL_W-1:0]  cur_col, cur_ocol;
  logic [ROW_W-1:0]  cur_row;
  logic [DLY_W-1:0]  cur_lead;
  logic              cur_complete;
  logic [OROW_W-1:0] cur_orow;
  logic              cfg_hit;

  // Pipeline
  logic              s1_valid, s1_emit, s1_row0, s1_set, s1_last;
  logic [COL_W-1:0]  s1_col, s1_ocol;
  logic              byp_hit;
  logic [CNT_W-1:0]  byp_cnt;
  logic [CNT_W-1:0]  rd_cnt, old_cnt, cnt_new;
  logic              col_hit;
  logic              s2_emit, s2_last;
  logic [COL_W-1:0]  s2_ocol;
  win_ctrl_t         ctrl;
  logic              win_hit;
  out_beat_t         push_data;
  out_beat_t         fifo_data;
  logic              fifo_valid;
  logic [FIFO_CNT_W-1:0] fifo_count;
  logic [FIFO_CNT_W-1:0] pending;

  // Raster delay between a source pixel and the mask pixel it releases
  assign dly = DLY_W'(half) * (DLY_W'(wm1) + DLY_W'(1)) + DLY_W'(half);

  assign cfg_hit = cfg_wr_en &&
                   (cfg_index == CFG_RANGE || cfg_index == CFG_WIDTH ||
                    cfg_index == CFG_HEIGHT);

  // Hold input while padding the stream or while the queue could overflow
  assign pending   = fifo_count + FIFO_CNT_W'(s1_emit) + FIFO_CNT_W'(s2_emit);
  assign pad       = complete && (lead != dly);
  assign pix.ready = !pad && (pending < FIFO_CNT_W'(FIFO_DEPTH));

  // Decode the beat and work out the next frame position
  always_comb begin
    acc          = pix.valid && pix.ready;
    is_pixel     = acc && (pix.kind == KIND_PIXEL);
    restart_px   = is_pixel && complete;
    take         = is_pixel || (acc && complete);
    beat         = take || pad;
    set_px       = is_pixel && (pix.pixel_value != '0);
    cur_col      = restart_px ? '0 : s_col;
    cur_row      = restart_px ? '0 : s_row;
    cur_lead     = restart_px ? '0 : lead;
    cur_complete = restart_px ? 1'b0 : complete;
    cur_ocol     = restart_px ? '0 : out_col;
    cur_orow     = restart_px ? '0 : out_row;
    emit         = take && (cur_lead == dly);
    last_p       = (cur_ocol == wm1) && (cur_orow == hm1);

    s_col_next    = s_col;
    s_row_next    = s_row;
    lead_next     = lead;
    complete_next = complete;
    out_col_next  = out_col;
    out_row_next  = out_row;

    if (beat) begin
      complete_next = cur_complete;
      if (cur_col == wm1) begin
        s_col_next = '0;
        s_row_next = cur_row + ROW_W'(1);
        if (is_pixel && cur_row == {1'b0, hm1}) begin
          complete_next = 1'b1;
        end
      end else begin
        s_col_next = cur_col + COL_W'(1);
        s_row_next = cur_row;
      end
      lead_next    = (cur_lead == dly) ? dly : cur_lead + DLY_W'(1);
      out_col_next = cur_ocol;
      out_row_next = cur_orow;
    end

    if (emit) begin
      if (last_p) begin
        s_col_next    = '0;
        s_row_next    = '0;
        lead_next     = '0;
        complete_next = 1'b0;
        out_col_next  = '0;
        out_row_next  = '0;
      end else if (cur_ocol == wm1) begin
        out_col_next = '0;
        out_row_next = cur_orow + OROW_W'(1);
      end else begin
        out_col_next = cur_ocol + COL_W'(1);
      end
    end
  end

  // Configuration registers and frame counters
  always_ff @(posedge clk) begin
    if (rst) begin
      half     <= RST_RANGE;
      wm1      <= RST_WIDTH_M1;
      hm1      <= RST_HEIGHT_M1;
      s_col    <= '0;
      s_row    <= '0;
      lead     <= '0;
      complete <= 1'b0;
      out_col  <= '0;
      out_row  <= '0;
    end else begin
      s_col    <= s_col_next;
      s_row    <= s_row_next;
      lead     <= lead_next;
      complete <= complete_next;
      out_col  <= out_col_next;
      out_row  <= out_row_next;
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_RANGE:  half <= cfg_data[RANGE_W-1:0];
          CFG_WIDTH:  wm1  <= clamp_size_m1(cfg_data, CFG_DATA_W'(MAX_WIDTH));
          CFG_HEIGHT: hm1  <= OROW_W'(clamp_size_m1(cfg_data, CFG_DATA_W'(MAX_HEIGHT)));
          default: ;
        endcase
      end
      // Drop the frame in progress on a write to any known register
      if (cfg_hit) begin
        s_col    <= '0;
        s_row    <= '0;
        lead     <= '0;
        complete <= 1'b0;
        out_col  <= '0;
        out_row  <= '0;
      end
    end
  end

  // Per-column age of the last hit, in rows
  bsd_ram #(
    .WIDTH (CNT_W),
    .DEPTH (MAX_WIDTH)
  ) u_age_ram (
    .clk     (clk),
    .wr_en   (s1_valid),
    .wr_addr (s1_col),
    .wr_data (cnt_new),
    .rd_en   (beat),
    .rd_addr (cur_col),
    .rd_data (rd_cnt)
  );

  // Stage 1: update the column age, forward a write that raced the read
  always_comb begin
    old_cnt = byp_hit ? byp_cnt : rd_cnt;
    if (s1_row0) begin
      old_cnt = CNT_SAT;
    end
    if (s1_set) begin
      cnt_new = '0;
    end else if (old_cnt == CNT_SAT) begin
      cnt_new = CNT_SAT;
    end else begin
      cnt_new = old_cnt + CNT_W'(1);
    end
    col_hit = cnt_new <= {half, 1'b0};
  end

  // Pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_emit  <= 1'b0;
      s2_emit  <= 1'b0;
      byp_hit  <= 1'b0;
    end else begin
      s1_valid <= beat;
      s1_emit  <= emit;
      s2_emit  <= s1_emit;
      byp_hit  <= s1_valid && (s1_col == cur_col);
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    byp_cnt <= cnt_new;
    s1_col  <= cur_col;
    s1_row0 <= cur_row == '0;
    s1_set  <= set_px;
    s1_ocol <= cur_ocol;
    s1_last <= last_p;
    s2_ocol <= s1_ocol;
    s2_last <= s1_last;
  end

  // Stage 2: horizontal window over the cell row
  assign ctrl.half  = half;
  assign ctrl.col_p = s2_ocol;
  assign ctrl.rem   = wm1 - s2_ocol;

  bsd_chain u_chain (
    .clk     (clk),
    .advance (s1_valid),
    .bit_in  (col_hit),
    .ctrl    (ctrl),
    .hit     (win_hit)
  );

  assign push_data.mask_value = win_hit ? MASK_ON : '0;
  assign push_data.frame_last = s2_last;

  bsd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (s2_emit),
    .push_data (push_data),
    .take      (mask.ready),
    .valid     (fifo_valid),
    .data      (fifo_data),
    .count     (fifo_count)
  );

  assign mask.valid      = fifo_valid;
  assign mask.mask_value = fifo_data.mask_value;
  assign mask.frame_last = fifo_data.frame_last;

endmodule

`default_nettype wire

### rtl/bsd_checker.sv
// Port-level checks for the dilation unit, bound to the top level.
// Depends on bsd_pkg for the mask constant.
`default_nettype none

module bsd_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      mask_valid,
  input wire logic                      mask_ready,
  input wire logic [bsd_pkg::PIX_W-1:0] mask_value,
  input wire logic                      frame_last
);
  import bsd_pkg::*;

  // Mask beats are strictly binary
  a_binary: assert property (@(posedge clk) disable iff (rst)
    mask_valid |-> (mask_value == '0 || mask_value == MASK_ON))
    else $error("mask beat is neither 0 nor full scale");

  // Nothing pending straight after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !mask_valid)
    else $error("mask beat offered after reset");

  // A stalled beat stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    mask_valid && !mask_ready |=> mask_valid)
    else $error("stalled mask beat withdrawn");

  // A stalled beat keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    mask_valid && !mask_ready |=> $stable(mask_value) && $stable(frame_last))
    else $error("stalled mask beat changed");

endmodule

bind binary_square_dilation_unit bsd_checker u_bsd_checker (
  .clk        (clk),
  .rst        (rst),
  .mask_valid (mask.valid),
  .mask_ready (mask.ready),
  .mask_value (mask.mask_value),
  .frame_last (mask.frame_last)
);

`default_nettype wire

### dv/binary_square_dilation_unit_test.sv
`timescale 1ns / 100ps
// Self-checking bench for binary_square_dilation_unit: drives pixel and flush beats,
// predicts every mask beat with a behavioural window model and checks them in order.
// Depends on bsd_pkg and the bsd_in_if / bsd_out_if stream interfaces.

module binary_square_dilation_unit_test;
  import bsd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic KIND_FLUSH    = 1'b1;
  localparam int   IDLE_MAX      = 16;
  localparam int   SETTLE_CYCLES = 4;
  localparam int   RANDOM_ITEMS  = 900;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_RANGE;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  bsd_in_if  pix_if ();
  bsd_out_if mask_if ();

  binary_square_dilation_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix       (pix_if),
    .mask      (mask_if)
  );

  // Window model state
  bit [MAX_WIDTH-1:0]    hit_rows [MAX_HEIGHT];
  logic [RANGE_W-1:0]    win_range;
  logic [CFG_DATA_W-1:0] frm_w;
  logic [CFG_DATA_W-1:0] frm_h;
  logic [COL_W-1:0]      in_col;
  logic [OROW_W-1:0]     in_row;
  int unsigned           out_pos;
  bit                    frame_done;

  out_beat_t   mask_expected [$];
  out_beat_t   mask_want;
  int          fail_count   = 0;
  int          random_items = 0;
  bit          idle_on      = 1'b1;
  int unsigned sink_wait    = 0;
  int unsigned sink_draw;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Hold the run to a fixed ceiling
  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Mask side: while idle_on is set, stall for a random number of cycles after each beat
  always @(posedge clk) begin
    if (rst) begin
      mask_if.ready <= 1'b0;
      sink_wait     <= 0;
    end else if (mask_if.valid && mask_if.ready) begin
      sink_draw = idle_on ? $urandom_range(IDLE_MAX, 0) : 0;
      mask_if.ready <= (sink_draw == 0);
      sink_wait     <= (sink_draw == 0) ? 0 : sink_draw - 1;
    end else if (sink_wait != 0) begin
      mask_if.ready <= 1'b0;
      sink_wait     <= sink_wait - 1;
    end else begin
      mask_if.ready <= 1'b1;
    end
  end

  // Compare each mask beat against the oldest prediction
  always @(posedge clk) begin
    if (!rst && mask_if.valid && mask_if.ready) begin
      if (mask_expected.size() == 0) begin
        $error("mask beat with nothing predicted: mask_value %0d frame_last %0b",
               mask_if.mask_value, mask_if.frame_last);
        fail_count++;
      end else begin
        mask_want = mask_expected.pop_front();
        if (mask_if.mask_value !== mask_want.mask_value) begin
          $error("mask_value mismatch: expected %0d, got %0d",
                 mask_want.mask_value, mask_if.mask_value);
          fail_count++;
        end
        if (mask_if.frame_last !== mask_want.frame_last) begin
          $error("frame_last mismatch: expected %0b, got %0b",
                 mask_want.frame_last, mask_if.frame_last);
          fail_count++;
        end
      end
    end
  end

  function automatic void restart_frame();
    in_col     = '0;
    in_row     = '0;
    out_pos    = 0;
    frame_done = 1'b0;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] v,
                                                      input logic [CFG_DATA_W-1:0] lim);
    if (v == '0) begin
      return 1;
    end
    return (v > lim) ? lim : v;
  endfunction

  // Track a register write; any known register restarts the frame
  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] index,
                                    input logic [CFG_DATA_W-1:0] data);
    case (index)
      CFG_RANGE: begin
        win_range = data[RANGE_W-1:0];
      end
      CFG_WIDTH: begin
        frm_w = clamp_dim(data, MAX_WIDTH);
      end
      CFG_HEIGHT: begin
        frm_h = clamp_dim(data, MAX_HEIGHT);
      end
      default: begin
        return;
      end
    endcase
    restart_frame();
  endfunction

  // True when any set source pixel lies in the clipped square around pos
  function automatic bit window_set(input int unsigned pos);
    int unsigned row, col, r0, r1, c0, c1, r, c;
    row = pos / frm_w;
    col = pos % frm_w;
    r0  = (row > win_range) ? row - win_range : 0;
    c0  = (col > win_range) ? col - win_range : 0;
    r1  = row + win_range;
    c1  = col + win_range;
    if (r1 > frm_h - 1) r1 = frm_h - 1;
    if (c1 > frm_w - 1) c1 = frm_w - 1;
    for (r = r0; r <= r1; r++) begin
      for (c = c0; c <= c1; c++) begin
        if (hit_rows[r][c]) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void release_mask();
    out_beat_t   beat;
    int unsigned frame_px;
    frame_px        = frm_w * frm_h;
    beat.mask_value = window_set(out_pos) ? MASK_ON : '0;
    beat.frame_last = (out_pos == frame_px - 1);
    mask_expected.push_back(beat);
    out_pos++;
    if (out_pos >= frame_px) restart_frame();
  endfunction

  // Advance the model by one accepted beat
  function automatic void predict_beat(input logic kind, input logic [PIX_W-1:0] value);
    int unsigned raster, delay;
    if (kind != KIND_PIXEL) begin
      if (frame_done) release_mask();
      return;
    end
    if (frame_done) restart_frame();
    hit_rows[in_row][in_col] = (value != '0);
    raster = in_row * frm_w + in_col;
    if (in_col + 1 >= frm_w) begin
      in_col = '0;
      if (in_row + 1 >= frm_h) begin
        in_row     = '0;
        frame_done = 1'b1;
      end else begin
        in_row++;
      end
    end else begin
      in_col++;
    end
    delay = win_range * frm_w + win_range;
    if (raster >= delay) release_mask();
  endfunction

  function automatic logic [PIX_W-1:0] draw_pixel(input int unsigned density);
    return ($urandom_range(7, 0) < density) ? PIX_W'($urandom_range(255, 1)) : '0;
  endfunction

  // Offer one beat after a random gap and wait for it to be taken
  task automatic send_beat(input logic kind, input logic [PIX_W-1:0] value);
    int unsigned gap;
    gap = idle_on ? $urandom_range(IDLE_MAX, 0) : 0;
    if (gap != 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_if.valid       <= 1'b1;
    pix_if.kind        <= kind;
    pix_if.pixel_value <= value;
    do @(posedge clk); while (!pix_if.ready);
    predict_beat(kind, value);
  endtask

  task automatic send_pixels(input int unsigned count, input int unsigned density);
    int unsigned i;
    for (i = 0; i < count; i++) send_beat(KIND_PIXEL, draw_pixel(density));
  endtask

  task automatic drain_frame();
    while (frame_done) send_beat(KIND_FLUSH, PIX_W'($urandom_range(255, 0)));
  endtask

  // Stop sending and wait until every predicted beat is out and the block is idle
  task automatic quiesce();
    pix_if.valid <= 1'b0;
    while (mask_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (!pix_if.ready) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    quiesce();
    cfg_wr_en <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    apply_reg(index, data);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Default 640x480 frame, range 1: a few set pixels in the first two rows
  task automatic test_reset_defaults();
    int i;
    for (i = 0; i < 650; i++) begin
      send_beat(KIND_PIXEL, (i == 3) ? 8'h01 : (i == 639) ? 8'hFF : (i == 645) ? 8'h80 : 8'h00);
    end
    quiesce();
  endtask

  // One-pixel frames from zero sizes, upper range bits ignored, delay past the frame
  task automatic test_tiny_frames();
    write_reg(CFG_WIDTH, '0);
    write_reg(CFG_HEIGHT, '0);
    write_reg(CFG_RANGE, {8'hA5, 3'd0});
    send_beat(KIND_PIXEL, 8'hFF);
    send_beat(KIND_PIXEL, 8'h00);
    send_beat(KIND_FLUSH, 8'h00);
    write_reg(CFG_RANGE, 11'h7F9);
    send_beat(KIND_PIXEL, 8'h02);
    send_beat(KIND_FLUSH, 8'hFF);
    send_beat(KIND_FLUSH, 8'h00);
    write_reg(CFG_WIDTH, 11'd2);
    write_reg(CFG_HEIGHT, 11'd3);
    write_reg(CFG_RANGE, 11'd7);
    send_pixels(5, 0);
    send_beat(KIND_PIXEL, 8'h40);
    drain_frame();
  endtask

  // Flush before the frame ends, partial drain cut short by a new pixel, flush with none pending
  task automatic test_flush_rules();
    write_reg(CFG_WIDTH, 11'd3);
    write_reg(CFG_HEIGHT, 11'd2);
    write_reg(CFG_RANGE, 11'd1);
    send_beat(KIND_FLUSH, 8'hFF);
    send_beat(KIND_PIXEL, 8'h00);
    send_beat(KIND_PIXEL, 8'h01);
    send_beat(KIND_FLUSH, 8'h00);
    send_beat(KIND_PIXEL, 8'h00);
    send_beat(KIND_PIXEL, 8'h00);
    send_beat(KIND_PIXEL, 8'h00);
    send_beat(KIND_PIXEL, 8'hFE);
    send_beat(KIND_FLUSH, 8'h00);
    send_beat(KIND_FLUSH, 8'h00);
    send_beat(KIND_PIXEL, 8'h10);
    send_pixels(5, 0);
    drain_frame();
    send_beat(KIND_FLUSH, 8'h00);
  endtask

  // Spare index leaves the frame alone; a real write mid-frame restarts it
  task automatic test_register_restart();
    write_reg(CFG_WIDTH, 11'd4);
    write_reg(CFG_HEIGHT, 11'd4);
    write_reg(CFG_RANGE, 11'd1);
    send_pixels(7, 3);
    write_reg(CFG_SPARE, 11'h7FF);
    send_pixels(9, 3);
    drain_frame();
    send_pixels(6, 4);
    write_reg(CFG_RANGE, 11'd1);
    send_pixels(16, 2);
    drain_frame();
  endtask

  // Largest sizes: a partial 1024x1024 frame, then one full 1024-pixel row
  task automatic test_widest_row();
    write_reg(CFG_WIDTH, 11'd1024);
    write_reg(CFG_HEIGHT, 11'd1024);
    write_reg(CFG_RANGE, 11'd7);
    send_pixels(20, 4);
    write_reg(CFG_HEIGHT, 11'd1);
    write_reg(CFG_RANGE, 11'd0);
    write_reg(CFG_WIDTH, 11'h7FF);
    send_pixels(1024, 1);
    drain_frame();
  endtask

  // Single column, height clamped from above the limit, widest window
  task automatic test_tallest_column();
    write_reg(CFG_WIDTH, 11'd1);
    write_reg(CFG_HEIGHT, 11'h7FF);
    write_reg(CFG_RANGE, 11'd7);
    send_pixels(1024, 1);
    drain_frame();
  endtask

  function automatic logic [CFG_DATA_W-1:0] draw_size(input int unsigned limit);
    int unsigned pick;
    pick = $urandom_range(9, 0);
    if (pick == 0) return '0;
    if (pick == 1) return CFG_DATA_W'($urandom_range(limit, 13));
    return CFG_DATA_W'($urandom_range(12, 1));
  endfunction

  // Mostly whole frames with random content; some partial frames, stray flushes, cut drains
  task automatic test_random_frames();
    int unsigned frame_px, count, density, i;
    while (random_items < RANDOM_ITEMS) begin
      idle_on = ($urandom_range(3, 0) != 0);
      if (random_items == 0 || $urandom_range(3, 0) == 0) begin
        if (random_items == 0 || $urandom_range(1, 0)) write_reg(CFG_WIDTH, draw_size(24));
        if (random_items == 0 || $urandom_range(1, 0)) write_reg(CFG_HEIGHT, draw_size(16));
        if (random_items == 0 || $urandom_range(1, 0)) begin
          write_reg(CFG_RANGE, {8'($urandom_range(255, 0)), 3'($urandom_range(7, 0))});
        end
      end
      frame_px = frm_w * frm_h;
      count    = ($urandom_range(7, 0) == 0) ? $urandom_range(frame_px, 1) : frame_px;
      density  = $urandom_range(8, 0);
      for (i = 0; i < count; i++) begin
        if ($urandom_range(15, 0) == 0) begin
          if (frame_done) random_items++;
          send_beat(KIND_FLUSH, PIX_W'($urandom_range(255, 0)));
        end
        send_beat(KIND_PIXEL, draw_pixel(density));
        random_items++;
      end
      while (frame_done && $urandom_range(19, 0) != 0) begin
        send_beat(KIND_FLUSH, PIX_W'($urandom_range(255, 0)));
        random_items++;
      end
      if ($urandom_range(9, 0) == 0) quiesce();
    end
    idle_on = 1'b1;
  endtask

  initial begin
    pix_if.valid       = 1'b0;
    pix_if.kind        = KIND_PIXEL;
    pix_if.pixel_value = '0;
    mask_if.ready      = 1'b0;
    win_range          = RST_RANGE;
    frm_w              = RST_WIDTH_M1 + 1;
    frm_h              = RST_HEIGHT_M1 + 1;
    restart_frame();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_tiny_frames();
    test_flush_rules();
    test_register_restart();
    test_widest_row();
    test_tallest_column();
    test_random_frames();

    quiesce();
    repeat (16) @(posedge clk);
    if (fail_count == 0 && mask_expected.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
